>>> rtl/core/rbvs_pkg.sv
// Shared field widths, register indexes and codes for the radial brush vertex stamp.
package rbvs_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned HEIGHT_W = 24;
    localparam int unsigned WEIGHT_W = 13;
    localparam int unsigned STEP_W   = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 13'd4096;
    localparam logic [KIND_W-1:0] KIND_RADIAL = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAINT_MODE   = 3'd0,
        REG_RAISE_MODE   = 3'd1,
        REG_BRUSH_KIND   = 3'd2,
        REG_BRUSH_RADIUS = 3'd3,
        REG_HEIGHT_STEP  = 3'd4,
        REG_WEIGHT_STEP  = 3'd5,
        REG_LAYER_SELECT = 3'd6
    } cfg_reg_t;

endpackage

>>> rtl/core/radial_brush_vertex_stamp.sv
// Radial brush vertex stamp: pipelined cosine-falloff terrain brush, one vertex per cycle.
// One vertex request is taken every cycle. The pipeline depth is set by the 17 one-bit
// square-root stages and the restoring divider that forms the falloff index, one stage per
// falloff index bit. A stall on the result side holds the whole pipeline. The falloff table
// is a constant ROM built at elaboration. Configuration writes are registered, and the
// squared radius is registered once more from the radius register.
module radial_brush_vertex_stamp #(
    parameter int unsigned FALLOFF_TABLE_DEPTH = 256,
    parameter int unsigned FALLOFF_FRAC_BITS   = 12
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [rbvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbvs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic [rbvs_pkg::COORD_W-1:0]         s_vertex_x,
    input  logic [rbvs_pkg::COORD_W-1:0]         s_vertex_z,
    input  logic signed [rbvs_pkg::HEIGHT_W-1:0] s_height_in,
    input  logic [rbvs_pkg::WEIGHT_W-1:0]        s_weight_a_in,
    input  logic [rbvs_pkg::WEIGHT_W-1:0]        s_weight_b_in,
    input  logic [rbvs_pkg::COORD_W-1:0]         s_centre_x,
    input  logic [rbvs_pkg::COORD_W-1:0]         s_centre_z,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [rbvs_pkg::HEIGHT_W-1:0] m_height_out,
    output logic [rbvs_pkg::WEIGHT_W-1:0]        m_weight_a_out,
    output logic [rbvs_pkg::WEIGHT_W-1:0]        m_weight_b_out,
    output logic                                 m_inside_brush
);

    localparam int unsigned DEPTH  = FALLOFF_TABLE_DEPTH;
    localparam int unsigned FB     = FALLOFF_FRAC_BITS;
    localparam int unsigned QW     = $clog2(DEPTH + 1);
    localparam int unsigned ROOT_N = 17;
    localparam int unsigned AW     = (ROOT_N + QW > 34) ? ROOT_N + QW : 34;
    localparam int unsigned ST_SUM   = 1;
    localparam int unsigned ST_SQ0   = 2;
    localparam int unsigned ST_SCALE = ST_SQ0 + ROOT_N;
    localparam int unsigned ST_DV0   = ST_SCALE + 1;
    localparam int unsigned ST_ROM   = ST_DV0 + QW;
    localparam int unsigned ST_MUL   = ST_ROM + 1;
    localparam int unsigned ST_OUT   = ST_MUL + 1;
    localparam int unsigned NSTG     = ST_OUT + 1;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic [FB:0] rom_t [DEPTH+1];

    typedef struct packed {
        logic                                 vld;
        logic signed [rbvs_pkg::HEIGHT_W-1:0] h;
        logic [rbvs_pkg::WEIGHT_W-1:0]        wa;
        logic [rbvs_pkg::WEIGHT_W-1:0]        wb;
        logic                                 ins;
        logic [AW-1:0]                        acc;
        logic [AW-1:0]                        root;
        logic [QW-1:0]                        q;
    } stage_t;

    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int i = 0; i <= int'(DEPTH); i++) begin
            x = (PI_HALF_Q30 * 64'(i)) / 64'(DEPTH);
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = $signed(term);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                t[i] = '0;
            end else begin
                r = (sum + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
                if (r > (64'sd1 <<< FB)) begin
                    r = 64'sd1 <<< FB;
                end
                t[i] = r[FB:0];
            end
        end
        return t;
    endfunction

    localparam rom_t FALLOFF_ROM = build_rom();

    logic                                 paint_mode_reg;
    logic                                 raise_mode_reg;
    logic [rbvs_pkg::KIND_W-1:0]          brush_kind_reg;
    logic [rbvs_pkg::COORD_W-1:0]         brush_radius_reg;
    logic [rbvs_pkg::STEP_W-1:0]          height_step_reg;
    logic [rbvs_pkg::WEIGHT_W-1:0]        weight_step_reg;
    logic                                 layer_select_reg;
    logic [2*rbvs_pkg::COORD_W-1:0]       radius_sq_reg;

    stage_t pipe_reg  [NSTG];
    stage_t pipe_next [NSTG];
    logic   ce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paint_mode_reg   <= 1'b1;
            raise_mode_reg   <= 1'b1;
            brush_kind_reg   <= rbvs_pkg::KIND_RADIAL;
            brush_radius_reg <= 16'd2560;
            height_step_reg  <= 16'd85;
            weight_step_reg  <= 13'd34;
            layer_select_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (rbvs_pkg::cfg_reg_t'(cfg_index))
                rbvs_pkg::REG_PAINT_MODE:   paint_mode_reg   <= cfg_data[0];
                rbvs_pkg::REG_RAISE_MODE:   raise_mode_reg   <= cfg_data[0];
                rbvs_pkg::REG_BRUSH_KIND:   brush_kind_reg   <= cfg_data[rbvs_pkg::KIND_W-1:0];
                rbvs_pkg::REG_BRUSH_RADIUS: brush_radius_reg <= cfg_data;
                rbvs_pkg::REG_HEIGHT_STEP:  height_step_reg  <= cfg_data;
                rbvs_pkg::REG_WEIGHT_STEP:  weight_step_reg  <= cfg_data[rbvs_pkg::WEIGHT_W-1:0];
                rbvs_pkg::REG_LAYER_SELECT: layer_select_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        radius_sq_reg <= 32'(brush_radius_reg) * 32'(brush_radius_reg);
    end

    assign ce      = !pipe_reg[NSTG-1].vld || m_ready;
    assign s_ready = ce;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        if (k == 0) begin : g_sq
            logic signed [rbvs_pkg::COORD_W:0] dx;
            logic signed [rbvs_pkg::COORD_W:0] dz;
            logic signed [2*rbvs_pkg::COORD_W+1:0] sqx;
            logic signed [2*rbvs_pkg::COORD_W+1:0] sqz;
            always_comb begin
                dx = $signed({1'b0, s_vertex_x}) - $signed({1'b0, s_centre_x});
                dz = $signed({1'b0, s_vertex_z}) - $signed({1'b0, s_centre_z});
                sqx = dx * dx;
                sqz = dz * dz;
                pipe_next[k]      = '0;
                pipe_next[k].vld  = s_valid;
                pipe_next[k].h    = s_height_in;
                pipe_next[k].wa   = s_weight_a_in;
                pipe_next[k].wb   = s_weight_b_in;
                pipe_next[k].acc  = AW'(unsigned'(sqx));
                pipe_next[k].root = AW'(unsigned'(sqz));
            end
        end else if (k == ST_SUM) begin : g_sum
            logic [AW-1:0] d2;
            always_comb begin
                d2 = pipe_reg[k-1].acc + pipe_reg[k-1].root;
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].acc  = d2;
                pipe_next[k].root = '0;
                pipe_next[k].ins  = (brush_kind_reg == rbvs_pkg::KIND_RADIAL)
                                    && (d2 <= AW'(radius_sq_reg));
            end
        end else if (k < ST_SCALE) begin : g_sqrt
            localparam int unsigned SH = 2 * (ROOT_N - 1 - (k - ST_SQ0));
            localparam logic [AW-1:0] BIT = AW'(1) << SH;
            logic [AW-1:0] trial;
            always_comb begin
                trial = pipe_reg[k-1].root + BIT;
                pipe_next[k] = pipe_reg[k-1];
                if (pipe_reg[k-1].acc >= trial) begin
                    pipe_next[k].acc  = pipe_reg[k-1].acc - trial;
                    pipe_next[k].root = (pipe_reg[k-1].root >> 1) + BIT;
                end else begin
                    pipe_next[k].root = pipe_reg[k-1].root >> 1;
                end
            end
        end else if (k == ST_SCALE) begin : g_scale
            always_comb begin
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].acc  = AW'(pipe_reg[k-1].root[ROOT_N-1:0] * AW'(DEPTH));
                pipe_next[k].root = '0;
                pipe_next[k].q    = '0;
            end
        end else if (k < ST_ROM) begin : g_div
            localparam int unsigned B = QW - 1 - (k - ST_DV0);
            logic [AW-1:0] sub;
            always_comb begin
                sub = AW'(brush_radius_reg) << B;
                pipe_next[k] = pipe_reg[k-1];
                if (pipe_reg[k-1].acc >= sub) begin
                    pipe_next[k].acc  = pipe_reg[k-1].acc - sub;
                    pipe_next[k].q[B] = 1'b1;
                end
            end
        end else if (k == ST_ROM) begin : g_rom
            logic [QW-1:0] idx;
            always_comb begin
                if (brush_radius_reg == '0) begin
                    idx = '0;
                end else if (pipe_reg[k-1].q > QW'(DEPTH)) begin
                    idx = QW'(DEPTH);
                end else begin
                    idx = pipe_reg[k-1].q;
                end
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].root = AW'(FALLOFF_ROM[idx]);
            end
        end else if (k == ST_MUL) begin : g_mul
            always_comb begin
                pipe_next[k]     = pipe_reg[k-1];
                pipe_next[k].acc = (AW'(height_step_reg) * pipe_reg[k-1].root
                                    + (AW'(1) << (FB - 1))) >> FB;
            end
        end else begin : g_out
            logic signed [rbvs_pkg::HEIGHT_W+2:0] hs;
            logic signed [rbvs_pkg::WEIGHT_W+1:0] wsel;
            logic signed [rbvs_pkg::WEIGHT_W+1:0] nw;
            logic [rbvs_pkg::WEIGHT_W-1:0]        wc;
            always_comb begin
                if (raise_mode_reg) begin
                    hs = 27'(pipe_reg[k-1].h)
                         + $signed({1'b0, pipe_reg[k-1].acc[ROOT_N:0]});
                end else begin
                    hs = 27'(pipe_reg[k-1].h)
                         - $signed({1'b0, pipe_reg[k-1].acc[ROOT_N:0]});
                end
                wsel = $signed({2'b00, layer_select_reg ? pipe_reg[k-1].wb : pipe_reg[k-1].wa});
                if (raise_mode_reg) begin
                    nw = wsel + $signed({2'b00, weight_step_reg});
                end else begin
                    nw = wsel - $signed({2'b00, weight_step_reg});
                end
                if (nw < 0) begin
                    wc = '0;
                end else if (nw > $signed({2'b00, rbvs_pkg::WEIGHT_ONE})) begin
                    wc = rbvs_pkg::WEIGHT_ONE;
                end else begin
                    wc = nw[rbvs_pkg::WEIGHT_W-1:0];
                end
                pipe_next[k] = pipe_reg[k-1];
                if (pipe_reg[k-1].ins) begin
                    if (paint_mode_reg) begin
                        if (layer_select_reg) begin
                            pipe_next[k].wb = wc;
                        end else begin
                            pipe_next[k].wa = wc;
                        end
                    end else if (hs > 27'sd8388607) begin
                        pipe_next[k].h = 24'sh7FFFFF;
                    end else if (hs < -27'sd8388608) begin
                        pipe_next[k].h = 24'sh800000;
                    end else begin
                        pipe_next[k].h = hs[rbvs_pkg::HEIGHT_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k].vld <= 1'b0;
            end else if (ce) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_valid        = pipe_reg[NSTG-1].vld;
    assign m_height_out   = pipe_reg[NSTG-1].h;
    assign m_weight_a_out = pipe_reg[NSTG-1].wa;
    assign m_weight_b_out = pipe_reg[NSTG-1].wb;
    assign m_inside_brush = pipe_reg[NSTG-1].ins;

endmodule

>>> rtl/core/rbvs_check.sv
// Port-level checker for the radial brush vertex stamp, bound to the top level.
module rbvs_check (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_inside_brush
);

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stage");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_brush))
        else $error("stalled result dropped or changed");

endmodule

bind radial_brush_vertex_stamp rbvs_check u_rbvs_check (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_inside_brush (m_inside_brush)
);

>>> test/rbvs_checker.sv
// Checker for the radial brush vertex stamp: predicts each vertex result and compares.
`timescale 1ns / 100ps
module rbvs_checker
    import rbvs_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [COORD_W-1:0]           s_vertex_x,
    input  logic [COORD_W-1:0]           s_vertex_z,
    input  logic signed [HEIGHT_W-1:0]   s_height_in,
    input  logic [WEIGHT_W-1:0]          s_weight_a_in,
    input  logic [WEIGHT_W-1:0]          s_weight_b_in,
    input  logic [COORD_W-1:0]           s_centre_x,
    input  logic [COORD_W-1:0]           s_centre_z,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [HEIGHT_W-1:0]   m_height_out,
    input  logic [WEIGHT_W-1:0]          m_weight_a_out,
    input  logic [WEIGHT_W-1:0]          m_weight_b_out,
    input  logic                         m_inside_brush,
    output int                           errors,
    output int                           pending
);

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 12;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [WEIGHT_W-1:0]        weight_a;
        logic [WEIGHT_W-1:0]        weight_b;
        logic                       in_brush;
    } stamp_t;

    stamp_t stamp_q[$];
    int unsigned cosine_rom [0:TABLE_DEPTH];

    logic                paint_mode;
    logic                raise_mode;
    logic [KIND_W-1:0]   brush_kind;
    logic [15:0]         brush_radius;
    logic [STEP_W-1:0]   height_step;
    logic [WEIGHT_W-1:0] weight_step;
    logic                layer_select;

    function automatic int unsigned cosine_q(longint unsigned i);
        longint unsigned x, x2, term;
        longint sum, r;
        x = (PI_HALF_Q30 * i) / TABLE_DEPTH;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) return 0;
        r = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > (longint'(1) << FRAC_BITS)) r = longint'(1) << FRAC_BITS;
        return int'(r);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, t;
        res = 0;
        for (int b = 17; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (t * t <= v) res = t;
        end
        return res;
    endfunction

    function automatic stamp_t stamp_vertex(
        logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vz, logic signed [HEIGHT_W-1:0] hin,
        logic [WEIGHT_W-1:0] wa_in, logic [WEIGHT_W-1:0] wb_in,
        logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cz);
        longint dx, dz, h, wa, wb, nw, delta;
        longint unsigned d2, rad, idx, f;
        stamp_t res;
        dx = longint'(vx) - longint'(cx);
        dz = longint'(vz) - longint'(cz);
        d2 = longint'(dx * dx) + longint'(dz * dz);
        rad = longint'(brush_radius);
        h = longint'(hin);
        wa = longint'(wa_in);
        wb = longint'(wb_in);
        res.in_brush = 1'b0;
        if (brush_kind == KIND_RADIAL && d2 <= rad * rad) begin
            res.in_brush = 1'b1;
            idx = 0;
            if (rad != 0) begin
                idx = (floor_sqrt(d2) * TABLE_DEPTH) / rad;
                if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
            end
            f = cosine_rom[idx];
            if (paint_mode) begin
                nw = layer_select ? wb : wa;
                nw = raise_mode ? nw + longint'(weight_step) : nw - longint'(weight_step);
                if (nw < 0) nw = 0;
                if (nw > longint'(WEIGHT_ONE)) nw = longint'(WEIGHT_ONE);
                if (layer_select) wb = nw;
                else wa = nw;
            end else begin
                delta = longint'((longint'(height_step) * f
                                  + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
                h = raise_mode ? h + delta : h - delta;
                if (h > 8388607) h = 8388607;
                if (h < -8388608) h = -8388608;
            end
        end
        res.height = h[HEIGHT_W-1:0];
        res.weight_a = wa[WEIGHT_W-1:0];
        res.weight_b = wb[WEIGHT_W-1:0];
        return res;
    endfunction

    initial begin
        for (int i = 0; i <= TABLE_DEPTH; i++) cosine_rom[i] = cosine_q(i);
    end

    assign pending = stamp_q.size();

    always @(posedge aclk) begin
        stamp_t want;
        if (!aresetn) begin
            errors = 0;
            paint_mode   <= 1'b1;
            raise_mode   <= 1'b1;
            brush_kind   <= KIND_RADIAL;
            brush_radius <= 16'd2560;
            height_step  <= 16'd85;
            weight_step  <= 13'd34;
            layer_select <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (stamp_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    want = stamp_q.pop_front();
                    if (m_height_out !== want.height) begin
                        $error("height_out: expected %0d, actual %0d", want.height,
                               m_height_out);
                        errors++;
                    end
                    if (m_weight_a_out !== want.weight_a) begin
                        $error("weight_a_out: expected %0d, actual %0d", want.weight_a,
                               m_weight_a_out);
                        errors++;
                    end
                    if (m_weight_b_out !== want.weight_b) begin
                        $error("weight_b_out: expected %0d, actual %0d", want.weight_b,
                               m_weight_b_out);
                        errors++;
                    end
                    if (m_inside_brush !== want.in_brush) begin
                        $error("inside_brush: expected %0d, actual %0d", want.in_brush,
                               m_inside_brush);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                stamp_q.insert(stamp_q.size(),
                               stamp_vertex(s_vertex_x, s_vertex_z, s_height_in,
                                            s_weight_a_in, s_weight_b_in,
                                            s_centre_x, s_centre_z));
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PAINT_MODE:   paint_mode   <= cfg_data[0];
                    REG_RAISE_MODE:   raise_mode   <= cfg_data[0];
                    REG_BRUSH_KIND:   brush_kind   <= cfg_data[KIND_W-1:0];
                    REG_BRUSH_RADIUS: brush_radius <= cfg_data;
                    REG_HEIGHT_STEP:  height_step  <= cfg_data[STEP_W-1:0];
                    REG_WEIGHT_STEP:  weight_step  <= cfg_data[WEIGHT_W-1:0];
                    REG_LAYER_SELECT: layer_select <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> test/tb_radial_brush_vertex_stamp.sv
// Testbench top for the radial brush vertex stamp: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_radial_brush_vertex_stamp;
    import rbvs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 64;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [COORD_W-1:0] s_vertex_x = '0, s_vertex_z = '0, s_centre_x = '0, s_centre_z = '0;
    logic signed [HEIGHT_W-1:0] s_height_in = '0;
    logic [WEIGHT_W-1:0] s_weight_a_in = '0, s_weight_b_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [HEIGHT_W-1:0] m_height_out;
    logic [WEIGHT_W-1:0] m_weight_a_out, m_weight_b_out;
    logic m_inside_brush;
    int errors, pending;
    int cycles = 0;
    bit calm = 1'b0;
    int cur_radius = 2560;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    radial_brush_vertex_stamp u_dut (.*);

    rbvs_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_radial_brush_vertex_stamp failed");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_brush(int paint, int raise, int kind, int radius, int hstep,
                             int wstep, int layer);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_PAINT_MODE, paint);
        write_reg(REG_RAISE_MODE, raise);
        write_reg(REG_BRUSH_KIND, kind);
        write_reg(REG_BRUSH_RADIUS, radius);
        write_reg(REG_HEIGHT_STEP, hstep);
        write_reg(REG_WEIGHT_STEP, wstep);
        write_reg(REG_LAYER_SELECT, layer);
        cur_radius = radius;
    endtask

    task automatic send_vertex(int vx, int vz, int h, int wa, int wb, int cx, int cz);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_vertex_x = vx[15:0];
        s_vertex_z = vz[15:0];
        s_height_in = h[23:0];
        s_weight_a_in = wa[12:0];
        s_weight_b_in = wb[12:0];
        s_centre_x = cx[15:0];
        s_centre_z = cz[15:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic int near_coord(int c, int lim);
        int v;
        v = c + $urandom_range(0, 2 * lim) - lim;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    task automatic random_vertex();
        int cx, cz, lim, h, wa, wb;
        cx = $urandom_range(0, 65535);
        cz = $urandom_range(0, 65535);
        lim = cur_radius + cur_radius / 4 + 1;
        if (lim > 65535) lim = 65535;
        case ($urandom_range(0, 3))
            0: h = $urandom_range(0, 32'hFFFFFF);
            1: h = 8388607 - $urandom_range(0, 70000);
            2: h = -8388608 + $urandom_range(0, 70000);
            default: h = $urandom_range(0, 4000) - 2000;
        endcase
        wa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096);
        wb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096);
        if ($urandom_range(0, 9) < 8)
            send_vertex(near_coord(cx, lim), near_coord(cz, lim), h, wa, wb, cx, cz);
        else
            send_vertex($urandom_range(0, 65535), $urandom_range(0, 65535), h, wa, wb, cx, cz);
    endtask

    task automatic directed_set();
        send_vertex(1000, 1000, 0, 0, 0, 1000, 1000);
        send_vertex(0, 0, 8388607, 4096, 4096, 0, 0);
        send_vertex(65535, 65535, -8388608, 0, 8191, 65535, 65535);
        send_vertex(3560, 1000, 100, 4096, 0, 1000, 1000);
        send_vertex(3561, 1000, -100, 8191, 4096, 1000, 1000);
        send_vertex(0, 65535, 12345, 2048, 2048, 65535, 0);
        send_vertex(2000, 2000, -1, 1, 4095, 1000, 1000);
        end_burst();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed_set();
        set_brush(0, 1, 1, 2560, 65535, 34, 0);
        directed_set();
        set_brush(0, 0, 1, 2560, 65535, 8191, 1);
        directed_set();
        set_brush(1, 1, 1, 2560, 0, 8191, 1);
        directed_set();
        set_brush(1, 0, 1, 0, 85, 4096, 0);
        write_reg(REG_SPARE, 16'hFFFF);
        directed_set();
        set_brush(0, 1, 0, 2560, 500, 34, 0);
        directed_set();

        for (int p = 0; p < 14; p++) begin
            case (p)
                0: set_brush(0, 1, 1, 1, 65535, 0, 0);
                1: set_brush(0, 0, 1, 65535, 65535, 0, 1);
                2: set_brush(1, 1, 1, 65535, 0, 4096, 0);
                3: set_brush(1, 0, 1, 0, 0, 8191, 1);
                4: set_brush(0, 1, 2, 2560, 85, 34, 0);
                5: set_brush(1, 1, 3, 2560, 85, 34, 1);
                default: set_brush($urandom_range(0, 1), $urandom_range(0, 1),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1,
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(1, 8000),
                                   $urandom_range(0, 65535), $urandom_range(0, 8191),
                                   $urandom_range(0, 1));
            endcase
            if (p == 13) calm = 1'b1;
            repeat (100) random_vertex();
            end_burst();
        end

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb_radial_brush_vertex_stamp passed");
        else
            $display("tb_radial_brush_vertex_stamp failed");
        $finish;
    end

endmodule
